[rtl/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types, codes and helpers for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int ROW_BITS   = 64;
    localparam int SLOT_IDX_W = 16;

    localparam logic [1:0] TIER_SOVEREIGN = 2'd0;
    localparam logic [1:0] TIER_INTERNAL  = 2'd1;
    localparam logic [1:0] TIER_REFERENCE = 2'd2;

    typedef enum logic [1:0] {
        OP_WRAP    = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_FREE   = 3'd3,
        ST_STALE  = 3'd4,
        ST_DENIED = 3'd5,
        ST_FULL   = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_ROW,
        BS_SLOT_W,
        BS_SLOT_R,
        BS_REL_ROW,
        BS_CNT_RD,
        BS_CNT_WR,
        BS_SUM_RD,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        t_opcode                 op;
        logic [63:0]             value;
        logic [1:0]              tier;
        logic [7:0]              cat_in;
        logic                    cat_ok;
        logic [7:0]              cat_map;
        logic [SLOT_IDX_W-1:0]   slot;
        logic [31:0]             gen;
        logic                    obs_on;
        logic [1:0]              obs_tier;
        t_status                 pre;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    function automatic logic tier_sees(logic [1:0] obs, logic [1:0] tgt);
        case (obs)
            TIER_SOVEREIGN: return 1'b1;
            TIER_INTERNAL:  return (tgt == TIER_INTERNAL) || (tgt == TIER_REFERENCE);
            TIER_REFERENCE: return tgt == TIER_REFERENCE;
            default:        return 1'b0;
        endcase
    endfunction

    // lowest set bit, byte lane first then bit within the lane
    function automatic logic [5:0] ffs64(logic [63:0] v);
        logic [7:0] nz;
        logic [2:0] b_sel;
        logic [2:0] bit_sel;
        logic [7:0] lane;
        for (int k = 0; k < 8; k++) begin
            nz[k] = |v[k*8 +: 8];
        end
        b_sel = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (nz[k]) begin
                b_sel = 3'(k);
            end
        end
        lane = v[{b_sel, 3'b000} +: 8];
        bit_sel = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (lane[k]) begin
                bit_sel = 3'(k);
            end
        end
        return {b_sel, bit_sel};
    endfunction

endpackage

[rtl/generational_handle_table.sv]
// ----------------------------------------------------------------------------
// generational_handle_table
// Each word passes the front queue and then the single back-end sequencer: words that
// fail the zero, range or full check and the unused opcode go straight to the summary
// read and done states, resolve and slot-level failures read the slot first, wrap and
// release also update the free bitmap and a category counter. The sequencer takes no
// new word until the last is done, and holds its done state while a result is stalled.
// Reset: a clearing pass over all SLOT_COUNT slots follows reset, o_stall held high.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int SLOT_COUNT     = 2048,
    parameter int CATEGORY_COUNT = 8,
    parameter int OTHER_CATEGORY = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_entry_value,
    input  logic [1:0]  i_entry_tier,
    input  logic [7:0]  i_entry_category,
    input  logic [63:0] i_handle_in,
    input  logic        i_observer_active,
    input  logic [1:0]  i_observer_tier,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_handle_out,
    output logic [63:0] o_resolved_value,
    output logic [2:0]  o_status,
    output logic [11:0] o_live_count,
    output logic [11:0] o_category_count
);

    ght_pkg::t_cmd      cmd;
    logic               q_valid;
    ght_pkg::t_back_ctl ctl;

    ght_front #(
        .SLOT_COUNT     (SLOT_COUNT),
        .CATEGORY_COUNT (CATEGORY_COUNT),
        .OTHER_CATEGORY (OTHER_CATEGORY)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_entry_value     (i_entry_value),
        .i_entry_tier      (i_entry_tier),
        .i_entry_category  (i_entry_category),
        .i_handle_in       (i_handle_in),
        .i_observer_active (i_observer_active),
        .i_observer_tier   (i_observer_tier),
        .i_ctl             (ctl),
        .o_q_valid         (q_valid),
        .o_cmd             (cmd)
    );

    ght_back #(
        .SLOT_COUNT     (SLOT_COUNT),
        .CATEGORY_COUNT (CATEGORY_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_cmd            (cmd),
        .o_ctl            (ctl),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_handle_out     (o_handle_out),
        .o_resolved_value (o_resolved_value),
        .o_status         (o_status),
        .o_live_count     (o_live_count),
        .o_category_count (o_category_count)
    );

`ifndef SYNTHESIS
    // a failed word carries neither a handle nor a value
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ght_pkg::ST_OK |-> o_handle_out == 64'd0 &&
        o_resolved_value == 64'd0)
        else $error("failed word carries payload");

    // a new handle never has generation zero
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_handle_out != 64'd0 |-> o_handle_out[31:0] != 32'd0 &&
        o_resolved_value == 64'd0)
        else $error("handle with zero generation");

    // no word enters or leaves the queue during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clearing |-> o_stall && !q_valid)
        else $error("queue active during clearing");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

[rtl/ght_front.sv]
// ----------------------------------------------------------------------------
// ght_front
// Takes input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ght_front #(
    parameter int SLOT_COUNT     = 2048,
    parameter int CATEGORY_COUNT = 8,
    parameter int OTHER_CATEGORY = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [63:0]        i_entry_value,
    input  logic [1:0]         i_entry_tier,
    input  logic [7:0]         i_entry_category,
    input  logic [63:0]        i_handle_in,
    input  logic               i_observer_active,
    input  logic [1:0]         i_observer_tier,
    input  ght_pkg::t_back_ctl i_ctl,
    output logic               o_q_valid,
    output ght_pkg::t_cmd      o_cmd
);

    localparam logic [7:0] MAP_CAT = (OTHER_CATEGORY < CATEGORY_COUNT) ?
                                     8'(OTHER_CATEGORY) : 8'(CATEGORY_COUNT - 1);

    ght_pkg::t_cmd r_q [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_cnt, n_cnt;
    ght_pkg::t_cmd cmd;
    logic          push;

    always_comb begin
        cmd          = '0;
        cmd.op       = ght_pkg::t_opcode'(i_opcode);
        cmd.value    = i_entry_value;
        cmd.tier     = i_entry_tier;
        cmd.cat_in   = i_entry_category;
        cmd.cat_ok   = {1'b0, i_entry_category} < 9'(CATEGORY_COUNT);
        cmd.cat_map  = cmd.cat_ok ? i_entry_category : MAP_CAT;
        cmd.slot     = i_handle_in[32 +: ght_pkg::SLOT_IDX_W];
        cmd.gen      = i_handle_in[31:0];
        cmd.obs_on   = i_observer_active;
        cmd.obs_tier = i_observer_tier;
        cmd.pre      = ght_pkg::ST_OK;
        case (cmd.op)
            ght_pkg::OP_WRAP: begin
                if (i_entry_value == 64'd0) begin
                    cmd.pre = ght_pkg::ST_ZERO;
                end
            end
            ght_pkg::OP_RESOLVE, ght_pkg::OP_RELEASE: begin
                if (i_handle_in == 64'd0) begin
                    cmd.pre = ght_pkg::ST_ZERO;
                end else if (i_handle_in[63:32] >= 32'(SLOT_COUNT)) begin
                    cmd.pre = ght_pkg::ST_RANGE;
                end
            end
            default: begin
                cmd.pre = ght_pkg::ST_OK;
            end
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_ctl.pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(push) - 2'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

[rtl/ght_back.sv]
// ----------------------------------------------------------------------------
// ght_back
// Sequencer over the slot store, free bitmap and category counters.
// ----------------------------------------------------------------------------
module ght_back #(
    parameter int SLOT_COUNT     = 2048,
    parameter int CATEGORY_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ght_pkg::t_cmd      i_cmd,
    output ght_pkg::t_back_ctl o_ctl,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_handle_out,
    output logic [63:0]        o_resolved_value,
    output logic [2:0]         o_status,
    output logic [11:0]        o_live_count,
    output logic [11:0]        o_category_count
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int ROWS   = (SLOT_COUNT + ght_pkg::ROW_BITS - 1) / ght_pkg::ROW_BITS;
    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW     = RIDX_W + 6;
    localparam int CAT_W  = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
    localparam int LIVE_W = $clog2(SLOT_COUNT + 1);

    typedef struct packed {
        logic [63:0]      value;
        logic [31:0]      gen;
        logic [1:0]       tier;
        logic [CAT_W-1:0] cat;
        logic             in_use;
    } t_slot;

    ght_pkg::t_bstate    r_state, n_state;
    logic [IDX_W-1:0]    r_clr, n_clr;
    ght_pkg::t_cmd       r_cmd, n_cmd;
    logic [RIDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]    r_slot, n_slot;
    ght_pkg::t_status    r_status, n_status;
    logic [63:0]         r_hout, n_hout;
    logic [63:0]         r_rval, n_rval;
    logic [CAT_W-1:0]    r_cat_tgt, n_cat_tgt;
    logic                r_inc, n_inc;
    logic [LIVE_W-1:0]   r_live, n_live;
    logic [ROWS-1:0]     r_row_free, n_row_free;
    logic [CATEGORY_COUNT-1:0] r_cvalid, n_cvalid;

    logic                r_o_valid, n_o_valid;
    logic [63:0]         r_o_handle, n_o_handle;
    logic [63:0]         r_o_rval, n_o_rval;
    logic [2:0]          r_o_status, n_o_status;
    logic [11:0]         r_o_live, n_o_live;
    logic [11:0]         r_o_ccnt, n_o_ccnt;

    t_slot               slot_mem [SLOT_COUNT];
    t_slot               r_slot_rd;
    logic                slot_we, slot_re;
    logic [IDX_W-1:0]    slot_wa, slot_ra;
    t_slot               slot_wd;

    logic [63:0]         row_mem [ROWS];
    logic [63:0]         r_row_rd;
    logic                row_we, row_re;
    logic [RIDX_W-1:0]   row_wa, row_ra;
    logic [63:0]         row_wd;

    logic [LIVE_W-1:0]   cnt_mem [CATEGORY_COUNT];
    logic [LIVE_W-1:0]   r_cnt_rd;
    logic                r_cnt_rdv;
    logic                cnt_we, cnt_re;
    logic [CAT_W-1:0]    cnt_wa, cnt_ra;
    logic [LIVE_W-1:0]   cnt_wd;

    logic [RIDX_W-1:0]   first_row;
    logic                any_row;
    logic [63:0]         row_mask, row_free_bits, pick;
    logic [5:0]          pick_bit;
    logic [SW-1:0]       pick_wide, slot_wide, clr_wide;
    logic                clr_row_ok;
    logic [31:0]         gen_claim, gen_next;
    logic [LIVE_W-1:0]   cnt_cur;
    logic                pop;

    // helpers
    always_comb begin
        first_row = '0;
        any_row   = 1'b0;
        for (int k = ROWS - 1; k >= 0; k--) begin
            if (r_row_free[k]) begin
                first_row = RIDX_W'(k);
                any_row   = 1'b1;
            end
        end
        // slots past the end of the table in the last row count as taken
        for (int b = 0; b < 64; b++) begin
            row_mask[b] = {1'b0, r_row, 6'(b)} < (SW + 1)'(SLOT_COUNT);
        end
        row_free_bits = ~r_row_rd & row_mask;
        pick_bit      = ght_pkg::ffs64(row_free_bits);
        pick          = 64'd1 << pick_bit;
        pick_wide     = {r_row, pick_bit};
        slot_wide     = SW'(r_slot);
        clr_wide      = SW'(r_clr);
        clr_row_ok    = clr_wide < SW'(ROWS);
        gen_claim     = (r_slot_rd.gen == 32'd0) ? 32'd1 : r_slot_rd.gen;
        gen_next      = (r_slot_rd.gen == 32'hFFFF_FFFF) ? 32'd1 : r_slot_rd.gen + 32'd1;
        cnt_cur       = r_cnt_rdv ? r_cnt_rd : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_slot     = r_slot;
        n_status   = r_status;
        n_hout     = r_hout;
        n_rval     = r_rval;
        n_cat_tgt  = r_cat_tgt;
        n_inc      = r_inc;
        n_live     = r_live;
        n_row_free = r_row_free;
        n_cvalid   = r_cvalid;
        n_o_valid  = r_o_valid;
        n_o_handle = r_o_handle;
        n_o_rval   = r_o_rval;
        n_o_status = r_o_status;
        n_o_live   = r_o_live;
        n_o_ccnt   = r_o_ccnt;
        pop        = 1'b0;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_wa    = '0;
        slot_ra    = '0;
        slot_wd    = '0;
        row_we     = 1'b0;
        row_re     = 1'b0;
        row_wa     = '0;
        row_ra     = '0;
        row_wd     = '0;
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_wa     = '0;
        cnt_ra     = '0;
        cnt_wd     = '0;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ght_pkg::BS_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr;
                row_we  = clr_row_ok;
                row_wa  = clr_wide[RIDX_W-1:0];
                n_clr   = r_clr + 1'b1;
                if (r_clr == IDX_W'(SLOT_COUNT - 1)) begin
                    n_state = ght_pkg::BS_IDLE;
                end
            end
            ght_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    pop      = 1'b1;
                    n_cmd    = i_cmd;
                    n_hout   = '0;
                    n_rval   = '0;
                    n_status = i_cmd.pre;
                    if (i_cmd.pre != ght_pkg::ST_OK || i_cmd.op == ght_pkg::OP_NONE) begin
                        n_state = ght_pkg::BS_SUM_RD;
                    end else if (i_cmd.op == ght_pkg::OP_WRAP) begin
                        if (!any_row) begin
                            n_status = ght_pkg::ST_FULL;
                            n_state  = ght_pkg::BS_SUM_RD;
                        end else begin
                            n_row   = first_row;
                            row_re  = 1'b1;
                            row_ra  = first_row;
                            n_state = ght_pkg::BS_ROW;
                        end
                    end else begin
                        slot_re = 1'b1;
                        slot_ra = i_cmd.slot[IDX_W-1:0];
                        n_slot  = i_cmd.slot[IDX_W-1:0];
                        n_state = ght_pkg::BS_SLOT_R;
                    end
                end
            end
            ght_pkg::BS_ROW: begin
                row_we            = 1'b1;
                row_wa            = r_row;
                row_wd            = r_row_rd | pick;
                n_row_free[r_row] = |(row_free_bits & ~pick);
                n_slot            = pick_wide[IDX_W-1:0];
                slot_re           = 1'b1;
                slot_ra           = pick_wide[IDX_W-1:0];
                n_state           = ght_pkg::BS_SLOT_W;
            end
            ght_pkg::BS_SLOT_W: begin
                slot_we        = 1'b1;
                slot_wa        = r_slot;
                slot_wd.value  = r_cmd.value;
                slot_wd.gen    = gen_claim;
                slot_wd.tier   = r_cmd.tier;
                slot_wd.cat    = r_cmd.cat_map[CAT_W-1:0];
                slot_wd.in_use = 1'b1;
                n_hout         = {32'(r_slot), gen_claim};
                n_live         = r_live + 1'b1;
                n_cat_tgt      = r_cmd.cat_map[CAT_W-1:0];
                n_inc          = 1'b1;
                n_state        = ght_pkg::BS_CNT_RD;
            end
            ght_pkg::BS_SLOT_R: begin
                n_state = ght_pkg::BS_SUM_RD;
                if (!r_slot_rd.in_use) begin
                    n_status = ght_pkg::ST_FREE;
                end else if (r_slot_rd.gen != r_cmd.gen) begin
                    n_status = ght_pkg::ST_STALE;
                end else if (r_cmd.op == ght_pkg::OP_RESOLVE) begin
                    if (r_cmd.obs_on && !ght_pkg::tier_sees(r_cmd.obs_tier, r_slot_rd.tier)) begin
                        n_status = ght_pkg::ST_DENIED;
                    end else begin
                        n_rval = r_slot_rd.value;
                    end
                end else begin
                    slot_we        = 1'b1;
                    slot_wa        = r_slot;
                    slot_wd        = r_slot_rd;
                    slot_wd.gen    = gen_next;
                    slot_wd.in_use = 1'b0;
                    n_cat_tgt      = r_slot_rd.cat;
                    n_inc          = 1'b0;
                    row_re         = 1'b1;
                    row_ra         = slot_wide[SW-1:6];
                    n_state        = ght_pkg::BS_REL_ROW;
                end
            end
            ght_pkg::BS_REL_ROW: begin
                row_we                        = 1'b1;
                row_wa                        = slot_wide[SW-1:6];
                row_wd                        = r_row_rd & ~(64'd1 << slot_wide[5:0]);
                n_row_free[slot_wide[SW-1:6]] = 1'b1;
                if (r_live != '0) begin
                    n_live = r_live - 1'b1;
                end
                n_state = ght_pkg::BS_CNT_RD;
            end
            ght_pkg::BS_CNT_RD: begin
                cnt_re  = 1'b1;
                cnt_ra  = r_cat_tgt;
                n_state = ght_pkg::BS_CNT_WR;
            end
            ght_pkg::BS_CNT_WR: begin
                cnt_we = 1'b1;
                cnt_wa = r_cat_tgt;
                if (r_inc) begin
                    cnt_wd = cnt_cur + 1'b1;
                end else if (cnt_cur != '0) begin
                    cnt_wd = cnt_cur - 1'b1;
                end else begin
                    cnt_wd = cnt_cur;
                end
                n_cvalid[r_cat_tgt] = 1'b1;
                n_state             = ght_pkg::BS_SUM_RD;
            end
            ght_pkg::BS_SUM_RD: begin
                if (r_cmd.cat_ok) begin
                    cnt_re = 1'b1;
                    cnt_ra = r_cmd.cat_in[CAT_W-1:0];
                end
                n_state = ght_pkg::BS_DONE;
            end
            ght_pkg::BS_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_handle = r_hout;
                    n_o_rval   = r_rval;
                    n_o_status = r_status;
                    n_o_live   = 12'(r_live);
                    n_o_ccnt   = (r_cmd.cat_ok && r_cnt_rdv) ? 12'(r_cnt_rd) : 12'd0;
                    n_state    = ght_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = ght_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ght_pkg::BS_CLEAR;
            r_clr      <= '0;
            r_live     <= '0;
            r_row_free <= '1;
            r_cvalid   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_live     <= n_live;
            r_row_free <= n_row_free;
            r_cvalid   <= n_cvalid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_row      <= n_row;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_hout     <= n_hout;
        r_rval     <= n_rval;
        r_cat_tgt  <= n_cat_tgt;
        r_inc      <= n_inc;
        r_o_handle <= n_o_handle;
        r_o_rval   <= n_o_rval;
        r_o_status <= n_o_status;
        r_o_live   <= n_o_live;
        r_o_ccnt   <= n_o_ccnt;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            r_slot_rd <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (row_re) begin
            r_row_rd <= row_mem[row_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_rd  <= cnt_mem[cnt_ra];
            r_cnt_rdv <= r_cvalid[cnt_ra];
        end
    end

    assign o_ctl.pop        = pop;
    assign o_ctl.clearing   = (r_state == ght_pkg::BS_CLEAR);
    assign o_valid          = r_o_valid;
    assign o_handle_out     = r_o_handle;
    assign o_resolved_value = r_o_rval;
    assign o_status         = r_o_status;
    assign o_live_count     = r_o_live;
    assign o_category_count = r_o_ccnt;

endmodule

[test/generational_handle_table_tb.sv]
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Drives wrap, resolve, release and unused-opcode words into the handle table and checks
// every result against a behavioural copy of the table kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_tb;

    localparam int SLOTS     = 2048;
    localparam int CATS      = 8;
    localparam int OTHER_CAT = 7;
    localparam int WD_LIMIT  = 20000;

    typedef struct packed {
        logic [63:0]      handle_out;
        logic [63:0]      resolved_value;
        ght_pkg::t_status status;
        logic [11:0]      live_count;
        logic [11:0]      category_count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [63:0] i_entry_value;
    logic [1:0]  i_entry_tier;
    logic [7:0]  i_entry_category;
    logic [63:0] i_handle_in;
    logic        i_observer_active;
    logic [1:0]  i_observer_tier;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_handle_out;
    logic [63:0] o_resolved_value;
    logic [2:0]  o_status;
    logic [11:0] o_live_count;
    logic [11:0] o_category_count;

    // bench copy of the table
    logic [63:0] tbl_value [SLOTS];
    logic [31:0] tbl_gen   [SLOTS];
    logic        tbl_used  [SLOTS];
    logic [1:0]  tbl_tier  [SLOTS];
    logic [2:0]  tbl_cat   [SLOTS];
    int          live_total;
    int          cat_total [CATS];

    t_result     pending_results[$];
    logic [63:0] live_handles[$];
    logic [63:0] dead_handles[$];
    int          errors = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          gap_left;
    int          burst_left;
    logic        stall_mode;

    generational_handle_table u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic tier_allows(logic [1:0] obs, logic [1:0] tgt);
        case (obs)
            ght_pkg::TIER_SOVEREIGN: return 1'b1;
            ght_pkg::TIER_INTERNAL:  return tgt == ght_pkg::TIER_INTERNAL ||
                                            tgt == ght_pkg::TIER_REFERENCE;
            ght_pkg::TIER_REFERENCE: return tgt == ght_pkg::TIER_REFERENCE;
            default:                 return 1'b0;
        endcase
    endfunction

    function automatic ght_pkg::t_status lookup_handle(logic [63:0] h);
        if (h == 64'd0) return ght_pkg::ST_ZERO;
        if (h[63:32] >= SLOTS) return ght_pkg::ST_RANGE;
        if (!tbl_used[h[63:32]]) return ght_pkg::ST_FREE;
        if (tbl_gen[h[63:32]] != h[31:0]) return ght_pkg::ST_STALE;
        return ght_pkg::ST_OK;
    endfunction

    // apply one word to the bench table and return the result it must give
    function automatic t_result predict_table_op(ght_pkg::t_opcode op, logic [63:0] val,
            logic [1:0] tier, logic [7:0] cat_in, logic [63:0] h,
            logic obs_on, logic [1:0] obs_tier);
        t_result r;
        int      cat;
        int      s;
        r = '0;
        r.status = ght_pkg::ST_OK;
        if (op == ght_pkg::OP_WRAP) begin
            if (val == 64'd0) begin
                r.status = ght_pkg::ST_ZERO;
            end else begin
                cat = (cat_in >= CATS) ? OTHER_CAT : cat_in;
                r.status = ght_pkg::ST_FULL;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_used[i]) begin
                        tbl_value[i] = val;
                        tbl_tier[i]  = tier;
                        tbl_used[i]  = 1'b1;
                        tbl_cat[i]   = 3'(cat);
                        if (tbl_gen[i] == 32'd0) tbl_gen[i] = 32'd1;
                        live_total++;
                        cat_total[cat]++;
                        r.handle_out = {32'(i), tbl_gen[i]};
                        live_handles.push_back(r.handle_out);
                        r.status = ght_pkg::ST_OK;
                        break;
                    end
                end
            end
        end else if (op == ght_pkg::OP_RESOLVE) begin
            r.status = lookup_handle(h);
            if (r.status == ght_pkg::ST_OK) begin
                s = h[63:32];
                if (obs_on && !tier_allows(obs_tier, tbl_tier[s]))
                    r.status = ght_pkg::ST_DENIED;
                else
                    r.resolved_value = tbl_value[s];
            end
        end else if (op == ght_pkg::OP_RELEASE) begin
            r.status = lookup_handle(h);
            if (r.status == ght_pkg::ST_OK) begin
                s = h[63:32];
                tbl_used[s] = 1'b0;
                if (cat_total[tbl_cat[s]] > 0) cat_total[tbl_cat[s]]--;
                tbl_gen[s] = tbl_gen[s] + 32'd1;
                if (tbl_gen[s] == 32'd0) tbl_gen[s] = 32'd1;
                if (live_total > 0) live_total--;
                dead_handles.push_back(h);
            end
        end
        r.live_count     = 12'(live_total);
        r.category_count = (cat_in < CATS) ? 12'(cat_total[cat_in]) : 12'd0;
        return r;
    endfunction

    // sender bursts and gaps
    task automatic send_word(ght_pkg::t_opcode op, logic [63:0] val, logic [1:0] tier,
            logic [7:0] cat, logic [63:0] h, logic obs_on, logic [1:0] obs_tier);
        if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        if (gap_left != 0) begin
            i_valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        burst_left--;
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_entry_value     <= val;
        i_entry_tier      <= tier;
        i_entry_category  <= cat;
        i_handle_in       <= h;
        i_observer_active <= obs_on;
        i_observer_tier   <= obs_tier;
        pending_results.push_back(predict_table_op(op, val, tier, cat, h, obs_on, obs_tier));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 3))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [63:0] pick_handle();
        int k;
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return {$urandom_range(SLOTS, 32'hffff_ffff), $urandom()};
            2: return {32'($urandom_range(0, SLOTS - 1)), $urandom()};
            3, 4: begin
                if (dead_handles.size() == 0) return 64'd0;
                k = $urandom_range(0, dead_handles.size() - 1);
                return dead_handles[k];
            end
            default: begin
                if (live_handles.size() == 0) return {$urandom(), $urandom()};
                k = $urandom_range(0, live_handles.size() - 1);
                return live_handles[k];
            end
        endcase
    endfunction

    task automatic test_directed();
        send_word(ght_pkg::OP_RESOLVE, 64'd0, 2'd0, 8'd0, 64'd0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_WRAP, 64'd0, 2'd0, 8'd0, 64'd0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_WRAP, '1, ght_pkg::TIER_SOVEREIGN, 8'd0, '1, 1'b1, 2'd3);
        send_word(ght_pkg::OP_WRAP, 64'h1234, ght_pkg::TIER_INTERNAL, 8'd255, '0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_WRAP, 64'h5678, ght_pkg::TIER_REFERENCE, 8'd7, '0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_WRAP, 64'h9abc, 2'd3, 8'd8, '0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_NONE, '1, 2'd3, 8'd7, '1, 1'b1, 2'd3);
        for (int o = 0; o < 4; o++) begin
            send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd1, {32'd1, 32'd1}, 1'b1, 2'(o));
            send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd2, {32'd2, 32'd1}, 1'b1, 2'(o));
        end
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd0, {32'd0, 32'd1}, 1'b0, 2'd3);
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd0, {32'd2048, 32'd1}, 1'b0, 2'd0);
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd0, {32'd5, 32'd1}, 1'b0, 2'd0);
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd0, {32'd0, 32'd2}, 1'b0, 2'd0);
        send_word(ght_pkg::OP_RELEASE, '0, 2'd0, 8'd0, {32'd3, 32'd1}, 1'b1, 2'd3);
        send_word(ght_pkg::OP_RELEASE, '0, 2'd0, 8'd7, {32'd3, 32'd1}, 1'b0, 2'd0);
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd7, {32'd3, 32'd1}, 1'b0, 2'd0);
        send_word(ght_pkg::OP_WRAP, 64'h1, ght_pkg::TIER_SOVEREIGN, 8'd3, '0, 1'b0, 2'd0);
        send_word(ght_pkg::OP_RESOLVE, '0, 2'd0, 8'd3, {32'd3, 32'd1}, 1'b0, 2'd0);
    endtask

    task automatic test_random_mix(int n);
        int               k;
        ght_pkg::t_opcode op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            op = (k < 40) ? ght_pkg::OP_WRAP : (k < 70) ? ght_pkg::OP_RESOLVE :
                 (k < 97) ? ght_pkg::OP_RELEASE : ght_pkg::OP_NONE;
            if (op == ght_pkg::OP_RELEASE && k < 90 && live_handles.size() != 0 &&
                dead_handles.size() < 64) begin
                // mostly release real handles so the table keeps churning
                k = $urandom_range(0, live_handles.size() - 1);
                send_word(op, rand64(), 2'($urandom), 8'($urandom_range(0, 9)),
                          live_handles[k], 1'($urandom), 2'($urandom));
                live_handles.delete(k);
            end else begin
                send_word(op, ($urandom_range(0, 15) == 0) ? 64'd0 : rand64() | 64'd1,
                          2'($urandom),
                          ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                                        8'($urandom_range(0, 7)),
                          pick_handle(), 1'($urandom), 2'($urandom));
            end
            if (dead_handles.size() > 200) dead_handles.delete(0);
            if (i == n / 2) drain_results();
        end
    endtask

    // release random slots with their current generation and wrap straight after
    task automatic test_slot_reuse();
        int s;
        for (int i = 0; i < 30; i++) begin
            s = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 1) == 0 && live_handles.size() != 0)
                s = live_handles[$urandom_range(0, live_handles.size() - 1)][63:32];
            send_word(ght_pkg::OP_RELEASE, '0, 2'd0, 8'($urandom_range(0, 8)),
                      {32'(s), tbl_gen[s]}, 1'b0, 2'd0);
            send_word(ght_pkg::OP_WRAP, 64'hffff_0000_0000_0001, 2'($urandom), 8'($urandom),
                      '0, 1'b0, 2'd0);
        end
        drain_results();
    endtask

    // result checker and stall pattern
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result with no word outstanding");
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_handle_out !== exp_r.handle_out) begin
                        $error("handle_out exp %h got %h", exp_r.handle_out, o_handle_out);
                        errors++;
                    end
                    if (o_resolved_value !== exp_r.resolved_value) begin
                        $error("resolved_value exp %h got %h", exp_r.resolved_value,
                               o_resolved_value);
                        errors++;
                    end
                    if (o_status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, o_status);
                        errors++;
                    end
                    if (o_live_count !== exp_r.live_count) begin
                        $error("live_count exp %0d got %0d", exp_r.live_count, o_live_count);
                        errors++;
                    end
                    if (o_category_count !== exp_r.category_count) begin
                        $error("category_count exp %0d got %0d", exp_r.category_count,
                               o_category_count);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
            i_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_opcode <= ght_pkg::OP_NONE;
        i_entry_value <= '0;
        i_entry_tier <= '0;
        i_entry_category <= '0;
        i_handle_in <= '0;
        i_observer_active <= 1'b0;
        i_observer_tier <= '0;
        gap_left = 0;
        burst_left = 0;
        live_total = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_gen[i] = '0;
            tbl_used[i] = 1'b0;
            tbl_value[i] = '0;
            tbl_tier[i] = '0;
            tbl_cat[i] = '0;
        end
        for (int c = 0; c < CATS; c++) cat_total[c] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(1000);
        test_slot_reuse();
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("covered directed checks, a random mix of all operations, slot reuse");
        $display("%0d results checked, %0d slots live at the end", results_seen, live_total);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
